### sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FRA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FRA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FRA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define FRA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/fra_pkg.sv
package fra_pkg;

    localparam int RING_W  = 25;
    localparam int ALIGN_W = 17;
    localparam int FENCE_W = 64;
    localparam int REQ_W   = 26;
    localparam logic [RING_W-1:0] RING_RESET = 25'd65536;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_WAITED      = 3'd1,
        ST_SUBMIT      = 3'd2,
        ST_TOO_BIG     = 3'd3,
        ST_TABLE_FULL  = 3'd4,
        ST_COMMIT_OVER = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_RETAIN  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_IDX_RST,
        CMD_RD,
        CMD_RD_LAST,
        CMD_RET_STEP,
        CMD_RET_END,
        CMD_PLACE_A,
        CMD_WRAP,
        CMD_PLACE_B,
        CMD_SRCH_NEXT,
        CMD_WAIT_TAKE,
        CMD_DIV_START,
        CMD_ALIGN_DONE,
        CMD_COMMIT_ADV,
        CMD_COMMIT_UPD,
        CMD_COMMIT_OVR,
        CMD_COMMIT_APP,
        CMD_RETAIN_UPD,
        CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        logic    load;
        logic    cfg_we;
        cmd_op_t op;
        status_t status;
    } fra_cmd_t;

    typedef struct packed {
        op_t  op;
        logic too_big;
        logic commit_over;
        logic cnt_zero;
        logic idx_lt_cnt;
        logic ret_hit;
        logic off_ge_cons;
        logic fit_a;
        logic wrap_ok;
        logic fit_b;
        logic srch_hit;
        logic fence_eq_cur;
        logic full;
        logic fence_lt_cur;
        logic div_done;
        logic out_busy;
    } fra_stat_t;

endpackage

### sv/fra_div.sv
module fra_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fra_pkg::RING_W-1:0]  x,
    input  logic [fra_pkg::ALIGN_W-1:0] a,
    output logic                        done,
    output logic [fra_pkg::RING_W-1:0]  aligned
);
    import fra_pkg::*;

    localparam int STEPS = REQ_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [REQ_W-1:0]   v_reg;
    logic [REQ_W-1:0]   sh_reg;
    logic [ALIGN_W-1:0] rem_reg;
    logic [ALIGN_W-1:0] a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [REQ_W-1:0]   v_start;
    logic [ALIGN_W:0]   trial;
    logic               fits;
    logic [ALIGN_W:0]   diff;
    logic [REQ_W-1:0]   base;

    assign v_start = {1'b0, x} + {{(REQ_W-ALIGN_W){1'b0}}, a} - {{(REQ_W-1){1'b0}}, 1'b1};
    assign trial   = {rem_reg, sh_reg[REQ_W-1]};
    assign fits    = trial >= {1'b0, a_reg};
    assign diff    = trial - {1'b0, a_reg};
    assign base    = v_reg - {{(REQ_W-ALIGN_W){1'b0}}, rem_reg};
    assign aligned = base[RING_W-1:0];
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            v_reg    <= '0;
            sh_reg   <= '0;
            rem_reg  <= '0;
            a_reg    <= '0;
        end
        else if (start)
        begin
            v_reg    <= v_start;
            sh_reg   <= v_start;
            rem_reg  <= '0;
            a_reg    <= a;
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
            sh_reg  <= {sh_reg[REQ_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

### sv/fra_ctrl.sv
module fra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               cfg_valid,
    input  fra_pkg::fra_stat_t stat,
    output fra_pkg::fra_cmd_t  cmd,
    output logic               idle
);
    import fra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RET_RD,
        S_RET_CHK,
        S_PLACE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DIV,
        S_DIV_WAIT,
        S_C_ADV,
        S_C_CMP,
        S_C_APP,
        S_RT_CHK,
        S_OUT
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    assign idle = state_reg == S_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.load    = 1'b0;
        cmd.cfg_we  = 1'b0;
        cmd.op      = CMD_NONE;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cfg_we = cfg_valid;
                cmd.load   = s_tvalid;
                if (s_tvalid)
                begin
                    status_next = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_RESERVE:
                    begin
                        if (stat.too_big)
                        begin
                            status_next = ST_TOO_BIG;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            cmd.op     = CMD_IDX_RST;
                            state_next = S_RET_RD;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (stat.commit_over)
                        begin
                            status_next = ST_COMMIT_OVER;
                            state_next  = S_OUT;
                        end
                        else
                            state_next = S_C_ADV;
                    end
                    OP_RETAIN:
                    begin
                        if (stat.cnt_zero)
                            state_next = S_OUT;
                        else
                        begin
                            cmd.op     = CMD_RD_LAST;
                            state_next = S_RT_CHK;
                        end
                    end
                    default:
                    begin
                        cmd.op     = CMD_CLEAR;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RET_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.op     = CMD_RD;
                    state_next = S_RET_CHK;
                end
                else
                begin
                    cmd.op     = CMD_RET_END;
                    state_next = S_PLACE;
                end
            end
            S_RET_CHK:
            begin
                if (stat.ret_hit)
                begin
                    cmd.op     = CMD_RET_STEP;
                    state_next = S_RET_RD;
                end
                else
                begin
                    cmd.op     = CMD_RET_END;
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_SRCH_RD;
                if (stat.off_ge_cons)
                begin
                    if (stat.fit_a)
                    begin
                        cmd.op     = CMD_PLACE_A;
                        state_next = S_DIV;
                    end
                    else if (stat.wrap_ok)
                    begin
                        cmd.op     = CMD_WRAP;
                        state_next = S_DIV;
                    end
                end
                else if (stat.fit_b)
                begin
                    cmd.op     = CMD_PLACE_B;
                    state_next = S_DIV;
                end
            end
            S_SRCH_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.op     = CMD_RD;
                    state_next = S_SRCH_CHK;
                end
                else
                begin
                    status_next = ST_SUBMIT;
                    state_next  = S_OUT;
                end
            end
            S_SRCH_CHK:
            begin
                if (!stat.srch_hit)
                begin
                    cmd.op     = CMD_SRCH_NEXT;
                    state_next = S_SRCH_RD;
                end
                else if (stat.fence_eq_cur)
                begin
                    status_next = ST_SUBMIT;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.op      = CMD_WAIT_TAKE;
                    status_next = ST_WAITED;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op     = CMD_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = CMD_ALIGN_DONE;
                    state_next = S_OUT;
                end
            end
            S_C_ADV:
            begin
                cmd.op = CMD_COMMIT_ADV;
                if (stat.cnt_zero)
                    state_next = S_C_APP;
                else
                    state_next = S_C_CMP;
            end
            S_C_APP:
            begin
                cmd.op     = CMD_COMMIT_APP;
                state_next = S_OUT;
            end
            S_C_CMP:
            begin
                cmd.op     = CMD_RD_LAST;
                state_next = S_RT_CHK;
            end
            S_RT_CHK:
            begin
                if (stat.op == OP_COMMIT)
                begin
                    if (stat.fence_eq_cur)
                        cmd.op = CMD_COMMIT_UPD;
                    else if (stat.full)
                    begin
                        cmd.op      = CMD_COMMIT_OVR;
                        status_next = ST_TABLE_FULL;
                    end
                    else
                        cmd.op = CMD_COMMIT_APP;
                end
                else if (stat.fence_lt_cur)
                    cmd.op = CMD_RETAIN_UPD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

### sv/fra_dp.sv
`include "assert_macros.svh"

module fra_dp #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fra_pkg::fra_cmd_t  cmd,
    input  logic [175:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic [24:0]        cfg_data,
    input  logic               m_tready,
    output fra_pkg::fra_stat_t stat,
    output logic               m_tvalid,
    output logic [119:0]       m_tdata,
    output logic [2:0]         m_tuser
);
    import fra_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW:0] SLOTS_W = (CW+1)'(SLOTS);

    logic [FENCE_W-1:0] fence_mem [SLOTS];
    logic [RING_W-1:0]  off_mem   [SLOTS];

    logic [RING_W-1:0]  ring_reg, offset_reg, space_reg, cons_reg, limit_reg;
    logic [RING_W-1:0]  bytes_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [FENCE_W-1:0] cur_reg, compl_reg, wait_reg;
    logic [FENCE_W-1:0] rd_fence_reg;
    logic [RING_W-1:0]  rd_off_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      cnt_reg, idx_reg;
    op_t                op_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [RING_W-1:0]  out_off_reg, out_free_reg;
    logic [FENCE_W-1:0] out_wait_reg;

    logic               div_done;
    logic [RING_W-1:0]  aligned;

    logic [ALIGN_W-1:0] in_align;
    logic [RING_W-1:0]  in_bytes;
    logic [AW-1:0]      a_idx, a_last, a_app, a_drop_idx, a_drop_next;
    logic [REQ_W-1:0]   ring_w, off_w, cons_w, gp_w, ring_m_off;
    logic               off_eq, off_gt, h1, h2, h3;
    logic [CW:0]        head_ext, cnt_ext, idx_ext;

    function automatic logic [AW-1:0] slot_of(input logic [CW:0] s);
        logic [CW:0] t;
        begin
            t = (s >= SLOTS_W) ? s - SLOTS_W : s;
            return t[AW-1:0];
        end
    endfunction

    assign in_bytes = s_tdata[24:0];
    assign in_align = (s_tdata[41:25] == '0) ? ALIGN_W'(1) : s_tdata[41:25];

    assign head_ext    = (CW+1)'(head_reg);
    assign cnt_ext     = {1'b0, cnt_reg};
    assign idx_ext     = {1'b0, idx_reg};
    assign a_idx       = slot_of(head_ext + idx_ext);
    assign a_last      = slot_of(head_ext + cnt_ext - (CW+1)'(1));
    assign a_app       = slot_of(head_ext + cnt_ext);
    assign a_drop_idx  = slot_of(head_ext + idx_ext);
    assign a_drop_next = slot_of(head_ext + idx_ext + (CW+1)'(1));

    assign ring_w     = {1'b0, ring_reg};
    assign off_w      = {1'b0, offset_reg};
    assign cons_w     = {1'b0, cons_reg};
    assign gp_w       = {1'b0, rd_off_reg};
    assign ring_m_off = ring_w - off_w;

    assign off_eq = offset_reg == rd_off_reg;
    assign off_gt = offset_reg > rd_off_reg;
    assign h1     = off_gt && (ring_m_off >= req_reg);
    assign h2     = off_gt && !h1 && (gp_w > req_reg);
    assign h3     = !off_eq && !off_gt && ((gp_w - off_w) > req_reg);

    always_comb
    begin
        stat.op           = op_reg;
        stat.too_big      = req_reg > ring_w;
        stat.commit_over  = ((off_w + {1'b0, bytes_reg}) > ring_w) || (bytes_reg > space_reg);
        stat.cnt_zero     = cnt_reg == '0;
        stat.idx_lt_cnt   = idx_reg < cnt_reg;
        stat.ret_hit      = compl_reg >= rd_fence_reg;
        stat.off_ge_cons  = offset_reg >= cons_reg;
        stat.fit_a        = req_reg <= ring_m_off;
        stat.wrap_ok      = req_reg < cons_w;
        stat.fit_b        = req_reg < (cons_w - off_w);
        stat.srch_hit     = off_eq || h1 || h2 || h3;
        stat.fence_eq_cur = rd_fence_reg == cur_reg;
        stat.full         = cnt_ext >= SLOTS_W;
        stat.fence_lt_cur = rd_fence_reg < cur_reg;
        stat.div_done     = div_done;
        stat.out_busy     = out_valid_reg && !m_tready;
    end

    fra_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == CMD_DIV_START),
        .x       (offset_reg),
        .a       (align_reg),
        .done    (div_done),
        .aligned (aligned)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_RD:
            begin
                rd_fence_reg <= fence_mem[a_idx];
                rd_off_reg   <= off_mem[a_idx];
            end
            CMD_RD_LAST:
            begin
                rd_fence_reg <= fence_mem[a_last];
                rd_off_reg   <= off_mem[a_last];
            end
            CMD_COMMIT_UPD:
                off_mem[a_last] <= offset_reg;
            CMD_COMMIT_OVR:
            begin
                fence_mem[a_last] <= cur_reg;
                off_mem[a_last]   <= offset_reg;
            end
            CMD_COMMIT_APP:
            begin
                fence_mem[a_app] <= cur_reg;
                off_mem[a_app]   <= offset_reg;
            end
            CMD_RETAIN_UPD:
                fence_mem[a_last] <= cur_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bytes_reg <= in_bytes;
            align_reg <= in_align;
            req_reg   <= {1'b0, in_bytes} + {{(REQ_W-ALIGN_W){1'b0}}, in_align};
            cur_reg   <= s_tdata[105:42];
            compl_reg <= s_tdata[169:106];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg       <= RING_RESET;
            offset_reg     <= '0;
            space_reg      <= '0;
            cons_reg       <= '0;
            limit_reg      <= '0;
            head_reg       <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            op_reg         <= OP_RESERVE;
            wait_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_off_reg    <= '0;
            out_free_reg   <= '0;
            out_wait_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
                op_reg <= op_t'(s_tuser);
            if (cmd.op == CMD_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.cfg_we)
            begin
                ring_reg   <= cfg_data;
                offset_reg <= '0;
                space_reg  <= '0;
                cons_reg   <= '0;
                head_reg   <= '0;
                cnt_reg    <= '0;
            end
            case (cmd.op)
                CMD_CLEAR:
                begin
                    offset_reg <= '0;
                    space_reg  <= '0;
                    cons_reg   <= '0;
                    head_reg   <= '0;
                    cnt_reg    <= '0;
                end
                CMD_IDX_RST:
                    idx_reg <= '0;
                CMD_RET_STEP:
                begin
                    cons_reg <= rd_off_reg;
                    idx_reg  <= idx_reg + CW'(1);
                end
                CMD_RET_END:
                begin
                    if (idx_reg != '0)
                    begin
                        head_reg <= a_drop_idx;
                        cnt_reg  <= cnt_reg - idx_reg;
                        if (offset_reg == cons_reg)
                        begin
                            offset_reg <= '0;
                            cons_reg   <= '0;
                            space_reg  <= ring_reg;
                        end
                    end
                    idx_reg <= '0;
                end
                CMD_PLACE_A:
                    limit_reg <= ring_reg;
                CMD_WRAP:
                begin
                    offset_reg <= '0;
                    limit_reg  <= cons_reg - RING_W'(1);
                end
                CMD_PLACE_B:
                    limit_reg <= cons_reg - RING_W'(1);
                CMD_SRCH_NEXT:
                    idx_reg <= idx_reg + CW'(1);
                CMD_WAIT_TAKE:
                begin
                    wait_reg <= rd_fence_reg;
                    if (off_eq)
                    begin
                        head_reg   <= a_app;
                        cnt_reg    <= '0;
                        offset_reg <= '0;
                        limit_reg  <= ring_reg;
                        cons_reg   <= '0;
                    end
                    else
                    begin
                        head_reg   <= a_drop_next;
                        cnt_reg    <= cnt_reg - idx_reg - CW'(1);
                        offset_reg <= h2 ? '0 : offset_reg;
                        limit_reg  <= h1 ? ring_reg : rd_off_reg - RING_W'(1);
                        cons_reg   <= rd_off_reg;
                    end
                end
                CMD_ALIGN_DONE:
                begin
                    offset_reg <= aligned;
                    space_reg  <= (limit_reg > aligned) ? limit_reg - aligned : '0;
                end
                CMD_COMMIT_ADV:
                begin
                    offset_reg <= offset_reg + bytes_reg;
                    space_reg  <= space_reg - bytes_reg;
                end
                CMD_COMMIT_APP:
                    cnt_reg <= cnt_reg + CW'(1);
                CMD_OUT:
                begin
                    out_status_reg <= cmd.status;
                    out_off_reg    <= offset_reg;
                    out_free_reg   <= space_reg;
                    out_wait_reg   <= (cmd.status == ST_WAITED) ? wait_reg : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b0, out_wait_reg, out_free_reg, out_off_reg};

    `FRA_ASSERT_ALWAYS(a_off_in_ring, clk, rst_n, offset_reg <= ring_reg, "offset beyond ring")
    `FRA_ASSERT_ALWAYS(a_space_in_ring, clk, rst_n, space_reg <= ring_reg, "space beyond ring")
    `FRA_ASSERT_ALWAYS(a_cons_in_ring, clk, rst_n, cons_reg <= ring_reg, "consumer beyond ring")
    `FRA_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_ext <= SLOTS_W, "mark count overflow")
    `FRA_ASSERT_IMPLIES(a_align_ready, clk, rst_n, cmd.op == CMD_ALIGN_DONE, div_done, "align early")

endmodule

### sv/fenced_ring_space_allocator_unit.sv
// One request at a time. Clear, retain and commit run through dispatch and the output state.
// Reserve retires marks, places the request, searches the marks if it does not fit, and aligns,
// the alignment done by the bit-serial alignment divider (one quotient bit a cycle).
// A result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous): ring size 65536, offset, space and consumer 0,
// mark table empty; no clearing pass.
module fenced_ring_space_allocator_unit #(
    parameter int MARK_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // byte_count[24:0], align_bytes[41:25], current_fence[105:42], completed_fence[169:106]
    input  logic [175:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // write_offset[24:0], free_bytes[49:25], wait_fence[113:50]
    output logic [119:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [24:0]  cfg_data
);
    import fra_pkg::*;

    fra_cmd_t  cmd;
    fra_stat_t stat;
    logic      idle;

    assign s_tready  = idle;
    assign cfg_ready = idle;

    fra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle)
    );

    fra_dp #(
        .SLOTS (MARK_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/tb_fenced_ring_space_allocator_unit.sv
`timescale 1ns / 100ps

module tb_fenced_ring_space_allocator_unit;
    import fra_pkg::*;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        op_t       op;
        bit [24:0] byte_count;
        bit [16:0] align_bytes;
        bit [63:0] cur_fence;
        bit [63:0] done_fence;
    } alloc_req_t;

    typedef struct {
        status_t   status;
        bit [24:0] write_offset;
        bit [24:0] free_bytes;
        bit [63:0] wait_fence;
    } alloc_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [24:0]  cfg_data;

    alloc_req_t    pending_reqs[$];
    alloc_result_t expected_results[$];

    // predictor state
    bit [63:0] ring_cap;
    bit [63:0] wr_off;
    bit [63:0] free_sp;
    bit [63:0] cons_pos;
    bit [63:0] mk_fence[SLOTS];
    bit [63:0] mk_off[SLOTS];
    int        mk_head;
    int        mk_cnt;

    int  failures;
    int  cfg_writes;
    bit  quiet;
    int  src_gap;
    int  sink_gap;
    int  stall_cycles;

    fenced_ring_space_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int slot_of(int i);
        return (mk_head + i) % SLOTS;
    endfunction

    function automatic bit [63:0] sat_sub(bit [63:0] a, bit [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic bit [63:0] round_up(bit [63:0] x, bit [63:0] a);
        return (x + a - 1) / a * a;
    endfunction

    function automatic void drop_marks(int n);
        if (n > mk_cnt)
            n = mk_cnt;
        mk_head = slot_of(n);
        mk_cnt  = mk_cnt - n;
    endfunction

    function automatic void empty_ring();
        wr_off   = 0;
        free_sp  = 0;
        cons_pos = 0;
        mk_head  = 0;
        mk_cnt   = 0;
    endfunction

    function automatic void retire_marks(bit [63:0] done);
        int n;
        n = 0;
        while (n < mk_cnt && done >= mk_fence[slot_of(n)])
        begin
            cons_pos = mk_off[slot_of(n)];
            n++;
        end
        if (n != 0)
        begin
            drop_marks(n);
            if (wr_off == cons_pos)
            begin
                wr_off   = 0;
                cons_pos = 0;
                free_sp  = ring_cap;
            end
        end
    endfunction

    function automatic status_t reserve_space(bit [63:0] req, bit [63:0] al, bit [63:0] cur,
                                              bit [63:0] done, output bit [63:0] wf);
        bit [63:0] gp, no, ns, ng, diff;
        bit        all_gone, hit;
        wf = 0;
        if (req > ring_cap)
            return ST_TOO_BIG;
        retire_marks(done);
        if (wr_off >= cons_pos)
        begin
            if (req <= sat_sub(ring_cap, wr_off))
            begin
                wr_off  = round_up(wr_off, al);
                free_sp = sat_sub(ring_cap, wr_off);
                return ST_OK;
            end
            if (req < cons_pos)
            begin
                wr_off  = 0;
                free_sp = cons_pos - 1;
                return ST_OK;
            end
        end
        else if (req < cons_pos - wr_off)
        begin
            wr_off  = round_up(wr_off, al);
            free_sp = sat_sub(cons_pos, wr_off + 1);
            return ST_OK;
        end
        for (int i = 0; i < mk_cnt; i++)
        begin
            gp       = mk_off[slot_of(i)];
            all_gone = 0;
            hit      = 0;
            if (wr_off == gp)
            begin
                no = 0; ns = ring_cap; ng = 0; all_gone = 1; hit = 1;
            end
            else if (wr_off > gp)
            begin
                if (sat_sub(ring_cap, wr_off) >= req)
                begin
                    no = wr_off; ns = sat_sub(ring_cap, wr_off); ng = gp; hit = 1;
                end
                else if (gp > req)
                begin
                    no = 0; ns = gp - 1; ng = gp; hit = 1;
                end
            end
            else if (gp - wr_off > req)
            begin
                no = wr_off; ns = gp - wr_off - 1; ng = gp; hit = 1;
            end
            if (!hit)
                continue;
            if (mk_fence[slot_of(i)] == cur)
                return ST_SUBMIT;
            wf = mk_fence[slot_of(i)];
            drop_marks(all_gone ? mk_cnt : i + 1);
            wr_off   = no;
            free_sp  = ns;
            cons_pos = ng;
            diff     = round_up(wr_off, al) - wr_off;
            wr_off   = wr_off + diff;
            free_sp  = sat_sub(free_sp, diff);
            return ST_WAITED;
        end
        return ST_SUBMIT;
    endfunction

    function automatic status_t commit_space(bit [63:0] n, bit [63:0] cur);
        int last;
        if (wr_off + n > ring_cap || n > free_sp)
            return ST_COMMIT_OVER;
        wr_off  = wr_off + n;
        free_sp = free_sp - n;
        if (mk_cnt != 0)
        begin
            last = slot_of(mk_cnt - 1);
            if (mk_fence[last] == cur)
            begin
                mk_off[last] = wr_off;
                return ST_OK;
            end
        end
        if (mk_cnt >= SLOTS)
        begin
            last           = slot_of(mk_cnt - 1);
            mk_fence[last] = cur;
            mk_off[last]   = wr_off;
            return ST_TABLE_FULL;
        end
        last           = slot_of(mk_cnt);
        mk_fence[last] = cur;
        mk_off[last]   = wr_off;
        mk_cnt++;
        return ST_OK;
    endfunction

    function automatic alloc_result_t predict_alloc(alloc_req_t r);
        alloc_result_t res;
        bit [63:0]     al, wf;
        int            last;
        al = (r.align_bytes == 0) ? 64'd1 : 64'(r.align_bytes);
        wf = 0;
        res.status = ST_OK;
        case (r.op)
            OP_RESERVE: res.status = reserve_space(64'(r.byte_count) + al, al, r.cur_fence,
                                                   r.done_fence, wf);
            OP_COMMIT:  res.status = commit_space(64'(r.byte_count), r.cur_fence);
            OP_RETAIN:
            begin
                if (mk_cnt != 0)
                begin
                    last = slot_of(mk_cnt - 1);
                    if (mk_fence[last] < r.cur_fence)
                        mk_fence[last] = r.cur_fence;
                end
            end
            default:    empty_ring();
        endcase
        res.write_offset = wr_off[24:0];
        res.free_bytes   = free_sp[24:0];
        res.wait_fence   = (res.status == ST_WAITED) ? wf : 64'd0;
        return res;
    endfunction

    // request source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(predict_alloc(pending_reqs.pop_front()));
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_reqs[0].op;
                    s_tdata  <= {6'd0, pending_reqs[0].done_fence, pending_reqs[0].cur_fence,
                                 pending_reqs[0].align_bytes, pending_reqs[0].byte_count};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and check
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d", m_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        failures++;
                    end
                    if (m_tdata[24:0] !== want.write_offset)
                    begin
                        $error("write_offset: expected %0d, actual %0d", want.write_offset,
                               m_tdata[24:0]);
                        failures++;
                    end
                    if (m_tdata[49:25] !== want.free_bytes)
                    begin
                        $error("free_bytes: expected %0d, actual %0d", want.free_bytes,
                               m_tdata[49:25]);
                        failures++;
                    end
                    if (m_tdata[113:50] !== want.wait_fence)
                    begin
                        $error("wait_fence: expected %0h, actual %0h", want.wait_fence,
                               m_tdata[113:50]);
                        failures++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ring size writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            ring_cap = 64'(cfg_data);
            empty_ring();
            cfg_valid <= 1'b0;
            cfg_writes++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** fenced_ring_space_allocator_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic add_req(op_t op, bit [24:0] n, bit [16:0] al, bit [63:0] cur, bit [63:0] done);
        alloc_req_t r;
        r.op          = op;
        r.byte_count  = n;
        r.align_bytes = al;
        r.cur_fence   = cur;
        r.done_fence  = done;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !s_tvalid);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_ring(bit [24:0] v);
        int seen;
        seen = cfg_writes;
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        wait (cfg_writes != seen);
        @(posedge clk);
    endtask

    function automatic bit [16:0] pick_align();
        case ($urandom_range(0, 5))
            0:       return 17'd1;
            1:       return 17'd4;
            2:       return 17'd16;
            3:       return 17'(1 << $urandom_range(0, 16));
            4:       return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(1, 100));
        endcase
    endfunction

    // well-formed batches with random content, plus noise
    task automatic fill_random(int count, bit [24:0] rs, bit hold_done);
        bit [63:0] cur, done;
        bit [24:0] n, top;
        int        made;
        cur  = {$urandom(), $urandom()} >> $urandom_range(1, 60);
        made = 0;
        top  = (rs > 25'd3) ? rs / 3 : 25'd2;
        while (made < count)
        begin
            done = hold_done ? 64'd0 : cur - $urandom_range(1, 4);
            if ($urandom_range(0, 9) < 8)
            begin
                n = 25'($urandom_range(0, top));
                add_req(OP_RESERVE, n, pick_align(), cur, done);
                if ($urandom_range(0, 7) == 0)
                    n = n + 25'($urandom_range(1, 64));
                else
                    n = 25'($urandom_range(0, n));
                add_req(OP_COMMIT, n, 17'($urandom()), cur, done);
                made += 2;
                if ($urandom_range(0, 9) == 0)
                begin
                    add_req(OP_RETAIN, 25'($urandom()), 17'($urandom()),
                            cur + $urandom_range(0, 2), done);
                    made++;
                end
                if ($urandom_range(0, 2) == 0)
                    cur = cur + 1;
            end
            else
            begin
                add_req(op_t'($urandom_range(0, 2)), 25'($urandom()), 17'($urandom()),
                        {$urandom(), $urandom()}, {$urandom(), $urandom()});
                if ($urandom_range(0, 3) == 0)
                    add_req(OP_CLEAR, 25'($urandom()), 17'($urandom()),
                            {$urandom(), $urandom()}, {$urandom(), $urandom()});
                made += 1;
            end
        end
        drain();
    endtask

    initial
    begin
        bit [63:0] all1;
        all1       = '1;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        failures   = 0;
        cfg_writes = 0;
        quiet      = 0;
        stall_cycles = 0;
        ring_cap   = 64'(RING_RESET);
        empty_ring();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_req(OP_RETAIN, 25'd0, 17'd1, 64'd7, 64'd0);
        add_req(OP_RESERVE, 25'h1FFFFFF, 17'd1, 64'd1, 64'd0);
        add_req(OP_RESERVE, 25'd100, 17'd0, 64'd1, 64'd0);
        add_req(OP_COMMIT, 25'd65536, 17'd1, 64'd1, 64'd0);
        add_req(OP_COMMIT, 25'd60, 17'd1, 64'd5, 64'd0);
        add_req(OP_COMMIT, 25'd20, 17'd1, 64'd3, 64'd0);
        add_req(OP_RETAIN, 25'd0, 17'd1, 64'd2, 64'd0);
        add_req(OP_RETAIN, 25'd0, 17'd1, 64'd9, 64'd0);
        add_req(OP_RESERVE, 25'd0, 17'd65536, 64'd9, 64'd0);
        add_req(OP_COMMIT, 25'd65000, 17'd1, 64'd9, 64'd0);
        add_req(OP_RESERVE, 25'd40000, 17'd1, 64'd9, 64'd4);
        add_req(OP_RESERVE, 25'd40000, 17'd1, 64'd10, 64'd4);
        add_req(OP_RESERVE, 25'd30000, 17'd8, 64'd10, 64'd5);
        add_req(OP_COMMIT, 25'd100, 17'd1, all1, all1);
        add_req(OP_RESERVE, 25'd10, 17'd1, all1, all1);
        add_req(OP_CLEAR, 25'h1FFFFFF, 17'h1FFFF, all1, all1);
        add_req(OP_RESERVE, 25'd65535, 17'd1, 64'd0, 64'd0);
        drain();

        fill_random(200, 25'd65536, 0);
        set_ring(25'd0);
        add_req(OP_RESERVE, 25'd0, 17'd1, 64'd1, 64'd0);
        add_req(OP_COMMIT, 25'd0, 17'd1, 64'd1, 64'd0);
        fill_random(40, 25'd0, 0);
        set_ring(25'h1FFFFFF);
        fill_random(150, 25'h1FFFFFF, 0);
        set_ring(25'd1);
        fill_random(40, 25'd1, 0);
        set_ring(25'd4096);
        fill_random(250, 25'd4096, 1);
        set_ring(25'($urandom_range(64, 1024)));
        fill_random(250, 25'(ring_cap), 0);
        set_ring(25'd65536);
        quiet = 1;
        fill_random(350, 25'd65536, 0);

        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("** fenced_ring_space_allocator_unit: PASSED **");
        else
            $display("** fenced_ring_space_allocator_unit: FAILED **");
        $finish;
    end

endmodule
